>>> design/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// shared constants, types and helpers of the signed binary to decimal ascii
// converter
// ----------------------------------------------------------------------------
package sbda_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CHAR_W         = 6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);
    localparam logic [CHAR_W-1:0] ASCII_NINE  = CHAR_W'(57);

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // decimal digits needed for an unsigned number of the given width
    // (1233 / 4096 approximates log10(2) from below)
    function automatic int num_digits(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

endpackage

>>> design/sbda_front.sv
// ----------------------------------------------------------------------------
// sbda_front
// accepts a value, splits it into sign and unsigned magnitude, hands it on
// ----------------------------------------------------------------------------
module sbda_front
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_push,
    output logic        [VALUE_BITS:0]   o_push_data,
    input  t_qstat                       i_qstat
);

    logic                  r_valid;
    logic                  n_valid;
    logic                  r_neg;
    logic [VALUE_BITS-1:0] r_mag;
    logic                  w_accept;
    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_mag;

    assign o_in_stall = r_valid && i_qstat.full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_qstat.full;

    // unsigned negate, so the most negative value wraps to its exact magnitude
    assign w_neg = i_value[VALUE_BITS-1];
    assign w_mag = w_neg ? (~VALUE_BITS'(i_value) + VALUE_BITS'(1)) : VALUE_BITS'(i_value);

    assign o_push_data = {r_neg, r_mag};

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= w_neg;
            r_mag <= w_mag;
        end
    end

endmodule

>>> design/sbda_queue.sv
// ----------------------------------------------------------------------------
// sbda_queue
// short fifo of classified values between front and back
// ----------------------------------------------------------------------------
module sbda_queue
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [VALUE_BITS:0] i_push_data,
    input  logic                i_pop,
    output logic [VALUE_BITS:0] o_pop_data,
    output t_qstat              o_qstat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [VALUE_BITS:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    assign o_qstat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_pop_data    = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> design/sbda_back.sv
// ----------------------------------------------------------------------------
// sbda_back
// shift-and-add-3 binary to bcd conversion and character emission
// ----------------------------------------------------------------------------
module sbda_back
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [VALUE_BITS:0] i_pop_data,
    output logic                o_pop,
    input  t_qstat              i_qstat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [CHAR_W-1:0]   o_character,
    output logic                o_last_char
);

    localparam int NDIG  = num_digits(VALUE_BITS);
    localparam int BCD_W = NDIG * 4;
    localparam int BIT_W = $clog2(VALUE_BITS + 1);
    localparam int DIG_W = $clog2(NDIG + 1);
    localparam logic [3:0] ADJ_MIN = 4'd5;
    localparam logic [3:0] ADJ_ADD = 4'd3;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CONV  = 5'b00010,
        S_SKIP  = 5'b00100,
        S_SIGN  = 5'b01000,
        S_DIGIT = 5'b10000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [BIT_W-1:0]      r_bit_cnt;
    logic [BIT_W-1:0]      n_bit_cnt;
    logic [DIG_W-1:0]      r_dig_cnt;
    logic [DIG_W-1:0]      n_dig_cnt;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  r_neg;
    logic                  n_neg;
    logic [VALUE_BITS-1:0] r_mag;
    logic [VALUE_BITS-1:0] n_mag;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      n_bcd;
    logic [BCD_W-1:0]      w_adj;
    logic [CHAR_W-1:0]     r_char;
    logic [CHAR_W-1:0]     n_char;
    logic                  r_last;
    logic                  n_last;
    logic [3:0]            w_top;
    logic                  w_out_free;

    assign w_top       = r_bcd[BCD_W-1 -: 4];
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last_char = r_last;
    assign o_pop       = (r_state == S_IDLE) && !i_qstat.empty;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= ADJ_MIN) ? r_bcd[4*i +: 4] + ADJ_ADD
                                                         : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_bit_cnt   = r_bit_cnt;
        n_dig_cnt   = r_dig_cnt;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_bcd       = r_bcd;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    n_neg     = i_pop_data[VALUE_BITS];
                    n_mag     = i_pop_data[VALUE_BITS-1:0];
                    n_bcd     = '0;
                    n_bit_cnt = BIT_W'(VALUE_BITS);
                    n_state   = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd     = {w_adj[BCD_W-2:0], r_mag[VALUE_BITS-1]};
                n_mag     = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt - BIT_W'(1);
                if (r_bit_cnt == BIT_W'(1)) begin
                    n_dig_cnt = DIG_W'(NDIG);
                    n_state   = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zero digits, keeping at least one
                if (w_top == 4'd0 && r_dig_cnt != DIG_W'(1)) begin
                    n_bcd     = {r_bcd[BCD_W-5:0], 4'd0};
                    n_dig_cnt = r_dig_cnt - DIG_W'(1);
                end else if (r_neg) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = ASCII_MINUS;
                    n_last      = 1'b0;
                    n_state     = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = ASCII_ZERO + CHAR_W'(w_top);
                    n_last      = (r_dig_cnt == DIG_W'(1));
                    n_bcd       = {r_bcd[BCD_W-5:0], 4'd0};
                    n_dig_cnt   = r_dig_cnt - DIG_W'(1);
                    if (r_dig_cnt == DIG_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_bit_cnt   <= '0;
            r_dig_cnt   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bit_cnt   <= n_bit_cnt;
            r_dig_cnt   <= n_dig_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule

>>> design/signed_binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// turns a signed two's-complement integer into decimal ascii text
// ----------------------------------------------------------------------------
// Each input transaction carries one signed integer of VALUE_BITS bits; the
// block answers with its decimal text, one output transaction per character,
// most significant first: a '-' for a negative value, then the digits with
// leading zeros dropped (zero gives a single '0'). o_last_char marks the final
// character; no terminator is sent. The most negative value converts exactly.
// A number goes through these steps in order: the value is taken from the
// queue, the shift-and-add-3 loop handles one bit per step, the scan drops
// leading zero digits out of D (the digit capacity, 10 at 32 bits), and each
// character is written into the output register once it is free. A second
// value can be accepted and classified while the previous one is still
// converting.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [VALUE_BITS-1:0] i_value,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic        [CHAR_W-1:0]     o_character,
    output logic                         o_last_char
);

    // classified value: sign bit on top of the unsigned magnitude
    logic                w_push;
    logic [VALUE_BITS:0] w_push_data;
    logic                w_pop;
    logic [VALUE_BITS:0] w_pop_data;
    t_qstat              w_qstat;

    // front: sign and magnitude, one transaction held while the queue is full
    sbda_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_qstat     (w_qstat)
    );

    // queue decouples the front from the slow conversion
    sbda_queue #(
        .VALUE_BITS (VALUE_BITS)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_qstat     (w_qstat)
    );

    // back: bcd conversion, zero suppression and the registered output
    sbda_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_data  (w_pop_data),
        .o_pop       (w_pop),
        .i_qstat     (w_qstat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

endmodule

>>> design/sbda_checker.sv
// ----------------------------------------------------------------------------
// sbda_checker
// port level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
module sbda_checker
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic signed [VALUE_BITS-1:0] i_value,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic        [CHAR_W-1:0]     o_character,
    input logic                         o_last_char
);

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_character) && $stable(o_last_char))
        else $error("output transaction changed under stall");

    // only a minus or a digit is ever sent
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_character == ASCII_MINUS) ||
            ((o_character >= ASCII_ZERO) && (o_character <= ASCII_NINE)))
        else $error("illegal character");

    // the sign is never the final character
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_character == ASCII_MINUS) |-> !o_last_char)
        else $error("minus marked as last character");

    // a stalled input transaction is still offered, unchanged, next cycle
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_value))
        else $error("input transaction changed under stall");

    // reset empties the output and frees the input
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block busy right after reset");

endmodule

bind signed_binary_to_decimal_ascii sbda_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_sbda_checker (.*);
